FILE: design/hsvhr_pkg.sv
// Shared types and constants for the HSV hue rotate / desaturate pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package hsvhr_pkg;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned CFG_W      = 9;
   localparam int unsigned CFG_IDX_W  = 1;
   localparam int unsigned HUE_W      = 15;
   localparam int unsigned Q16_W      = 17;
   localparam int unsigned DIV_STEPS  = 17;
   localparam int unsigned DIV_W      = 25;
   localparam int unsigned HUE_FULL   = 23040;
   localparam int unsigned HUE_SECTOR = 3840;
   localparam int unsigned Q16_ONE    = 65536;
   // floor(2^19 / 15), low side of the reciprocal
   localparam int unsigned RECIP_15   = 34952;

   localparam logic [CFG_W-1:0] HUE_OFFSET_RESET = 9'd120;
   localparam logic [CFG_W-1:0] SAT_GAIN_RESET   = 9'd192;

   localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 1'b0;
   localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN   = 1'b1;

   localparam logic [1:0] REGION_RED   = 2'd0;
   localparam logic [1:0] REGION_GREEN = 2'd1;
   localparam logic [1:0] REGION_BLUE  = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [1:0]       region;
      logic             neg;
   } side_type;

   typedef struct packed {
      logic [23:0]      num_s;
      logic [19:0]      num_h;
      logic [PIX_W-1:0] div_s;
      logic [PIX_W-1:0] div_h;
      side_type         side;
   } div_req_type;

   typedef struct packed {
      logic [Q16_W-1:0] q_s;
      logic [11:0]      q_h;
      logic             rem_nz;
      side_type         side;
   } div_rsp_type;

   // One restoring step: word is {remainder[7:0], numerator/quotient[16:0]}.
   function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                 input logic [PIX_W-1:0] d);
      logic [8:0] t;
      logic [8:0] dif;
      logic       ge;
      t   = w[24:16];
      dif = t - {1'b0, d};
      ge  = (t >= {1'b0, d});
      return {(ge ? dif[7:0] : t[7:0]), w[15:0], ge};
   endfunction

endpackage
`default_nettype wire

FILE: design/hsv_hue_rotate_desaturate.sv
// Top level of the HSV hue rotate / desaturate pixel pipeline.
// Depends on hsvhr_pkg, hsvhr_front, hsvhr_divpipe and hsvhr_back.
//
// Usage:
//   req_* is the pixel input stream, rsp_* the pixel output stream; one
//   request gives exactly one response, in order.
//   csr_we/csr_index/csr_wdata write hue_offset (index 0, degrees) and
//   saturation_gain (index 1, Q8); write only while the pipeline is empty.
// Pipeline: 1 front stage, 17 divider stages at one quotient bit each and
//   7 back-end stages.
// Throughput: one pixel per cycle while rsp_tready is high; every stage holds
//   a valid bit and fills bubbles independently, so a new request is accepted
//   while finished pixels wait at the output.
// Reset: synchronous; empties the pipeline and loads hue_offset = 120 and
//   saturation_gain = 192.
// Stall: when rsp_tready is low the output holds; upstream stages keep
//   filling until the pipe is full, then req_tready drops.
`default_nettype none
module hsv_hue_rotate_desaturate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
   input  logic        csr_we,
   input  logic [hsvhr_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [hsvhr_pkg::CFG_W-1:0]     csr_wdata
);
   import hsvhr_pkg::*;

   logic [CFG_W-1:0] hue_offset_ff;
   logic [CFG_W-1:0] sat_gain_ff;

   logic        front_valid, front_ready;
   div_req_type front_req;
   logic        div_valid, div_ready;
   div_rsp_type div_rsp;
   pixel_type   out_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_offset_ff <= HUE_OFFSET_RESET;
         sat_gain_ff   <= SAT_GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CFG_HUE_OFFSET: hue_offset_ff <= csr_wdata;
            CFG_SAT_GAIN:   sat_gain_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   hsvhr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pixel  (pixel_type'(req_tdata)),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_req   (front_req)
   );

   hsvhr_divpipe u_divpipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_req    (front_req),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_rsp   (div_rsp)
   );

   hsvhr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hue_offset (hue_offset_ff),
      .sat_gain   (sat_gain_ff),
      .in_valid   (div_valid),
      .in_ready   (div_ready),
      .in_rsp     (div_rsp),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixel  (out_pixel)
   );

   assign rsp_tdata = out_pixel;

   // empty output slot means the whole chain can take a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while output stage empty");

   a_hue_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CFG_HUE_OFFSET |=> hue_offset_ff == $past(csr_wdata))
      else $error("hue offset write lost");

   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && csr_index == CFG_SAT_GAIN |=> sat_gain_ff == $past(csr_wdata))
      else $error("saturation gain write lost");

endmodule
`default_nettype wire

FILE: design/hsvhr_front.sv
// Front stage: max/min, hue region and the two division operands.
// Depends on hsvhr_pkg.
`default_nettype none
module hsvhr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvhr_pkg::pixel_type   in_pixel,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvhr_pkg::div_req_type out_req
);
   import hsvhr_pkg::*;

   logic [PIX_W-1:0] mx;
   logic [PIX_W-1:0] mn;
   logic [PIX_W-1:0] delta;
   logic [PIX_W-1:0] mag8;
   logic [8:0]       diff;
   logic [8:0]       mag;
   logic             en;
   logic             valid_ff;
   div_req_type      req_in;
   div_req_type      req_ff;

   always_comb begin
      mx = in_pixel.red;
      mn = in_pixel.red;
      if (in_pixel.green > mx) mx = in_pixel.green;
      if (in_pixel.blue > mx) mx = in_pixel.blue;
      if (in_pixel.green < mn) mn = in_pixel.green;
      if (in_pixel.blue < mn) mn = in_pixel.blue;
      delta = mx - mn;
      req_in.side.value = mx;
      if (in_pixel.red == mx) begin
         req_in.side.region = REGION_RED;
         diff = {1'b0, in_pixel.green} - {1'b0, in_pixel.blue};
      end else if (in_pixel.green == mx) begin
         req_in.side.region = REGION_GREEN;
         diff = {1'b0, in_pixel.blue} - {1'b0, in_pixel.red};
      end else begin
         req_in.side.region = REGION_BLUE;
         diff = {1'b0, in_pixel.red} - {1'b0, in_pixel.green};
      end
      req_in.side.neg = diff[8];
      mag  = diff[8] ? (~diff + 9'd1) : diff;
      mag8 = mag[7:0];
      // 3840 * |diff| as 4096a - 256a
      req_in.num_h = {mag8, 12'b0} - {4'b0, mag8, 8'b0};
      req_in.num_s = {delta, 16'b0};
      // zero divisors only meet zero numerators: divide by one instead
      req_in.div_s = (mx == '0) ? 8'd1 : mx;
      req_in.div_h = (delta == '0) ? 8'd1 : delta;
   end

   assign en        = !valid_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = valid_ff;
   assign out_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         req_ff <= req_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/hsvhr_divpipe.sv
// Pipelined restoring dividers for saturation and hue, one quotient bit per stage.
// Depends on hsvhr_pkg.
`default_nettype none
module hsvhr_divpipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvhr_pkg::div_req_type in_req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvhr_pkg::div_rsp_type out_rsp
);
   import hsvhr_pkg::*;

   localparam int unsigned LAST = DIV_STEPS - 1;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [DIV_STEPS-1:0] en;
   logic [DIV_W-1:0]     ws_ff [DIV_STEPS];
   logic [DIV_W-1:0]     wh_ff [DIV_STEPS];
   logic [PIX_W-1:0]     ds_ff [DIV_STEPS];
   logic [PIX_W-1:0]     dh_ff [DIV_STEPS];
   side_type             side_ff [DIV_STEPS];

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_stage
         logic [DIV_W-1:0] ws_src;
         logic [DIV_W-1:0] wh_src;
         logic [PIX_W-1:0] ds_src;
         logic [PIX_W-1:0] dh_src;
         side_type         side_src;
         logic             valid_src;

         if (k == 0) begin : g_first
            assign ws_src    = {1'b0, in_req.num_s[23:17], in_req.num_s[16:0]};
            assign wh_src    = {5'b0, in_req.num_h[19:17], in_req.num_h[16:0]};
            assign ds_src    = in_req.div_s;
            assign dh_src    = in_req.div_h;
            assign side_src  = in_req.side;
            assign valid_src = in_valid;
         end else begin : g_next
            assign ws_src    = ws_ff[k-1];
            assign wh_src    = wh_ff[k-1];
            assign ds_src    = ds_ff[k-1];
            assign dh_src    = dh_ff[k-1];
            assign side_src  = side_ff[k-1];
            assign valid_src = valid_ff[k-1];
         end

         if (k == LAST) begin : g_en_last
            assign en[k] = !valid_ff[k] || out_ready;
         end else begin : g_en_mid
            assign en[k] = !valid_ff[k] || en[k+1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en[k]) begin
               valid_ff[k] <= valid_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en[k] && valid_src) begin
               ws_ff[k]   <= div_step(ws_src, ds_src);
               wh_ff[k]   <= div_step(wh_src, dh_src);
               ds_ff[k]   <= ds_src;
               dh_ff[k]   <= dh_src;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   assign in_ready       = en[0];
   assign out_valid      = valid_ff[LAST];
   assign out_rsp.q_s    = ws_ff[LAST][16:0];
   assign out_rsp.q_h    = wh_ff[LAST][11:0];
   assign out_rsp.rem_nz = (wh_ff[LAST][24:17] != '0);
   assign out_rsp.side   = side_ff[LAST];

endmodule
`default_nettype wire

FILE: design/hsvhr_back.sv
// Back end: hue rotation, saturation gain, sector split and HSV to RGB.
// Seven register stages; depends on hsvhr_pkg.
`default_nettype none
module hsvhr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [8:0]             hue_offset,
   input  logic [8:0]             sat_gain,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvhr_pkg::div_rsp_type in_rsp,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvhr_pkg::pixel_type   out_pixel
);
   import hsvhr_pkg::*;

   localparam int unsigned NSTG = 7;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] en;
   logic [NSTG-1:0] valid_src;

   // stage 1: signed hue, offset add, saturation product
   logic [15:0]      hsum1_in, hsum1_ff;
   logic [25:0]      sp1_in, sp1_ff;
   logic [PIX_W-1:0] v1_ff;
   // stage 2: hue wrap, saturation clamp
   logic [HUE_W-1:0] h2_in, h2_ff;
   logic [Q16_W-1:0] s2_in, s2_ff;
   logic [PIX_W-1:0] v2_ff;
   // stage 3: sector and remainder
   logic [2:0]       sec3_in, sec3_ff;
   logic [11:0]      rem3_in, rem3_ff;
   logic [Q16_W-1:0] s3_ff;
   logic [PIX_W-1:0] v3_ff;
   // stage 4: reciprocal estimate of the fraction
   logic [15:0]      q4_in, q4_ff;
   logic [11:0]      rem4_ff;
   logic [2:0]       sec4_ff;
   logic [Q16_W-1:0] s4_ff;
   logic [PIX_W-1:0] v4_ff;
   // stage 5: fraction correction
   logic [15:0]      f5_in, f5_ff;
   logic [2:0]       sec5_ff;
   logic [Q16_W-1:0] s5_ff;
   logic [PIX_W-1:0] v5_ff;
   // stage 6: factors
   logic [Q16_W-1:0] pf6_in, pf6_ff, qf6_in, qf6_ff, tf6_in, tf6_ff;
   logic [2:0]       sec6_ff;
   logic [PIX_W-1:0] v6_ff;
   // stage 7: output pixel
   pixel_type        pix7_in, pix7_ff;

   logic [HUE_W-1:0] q_ext, q_up, h_base;
   logic [17:0]      sat;
   logic [HUE_W-1:0] sec_base;
   logic [35:0]      recip_prod;
   logic [19:0]      x5, q15, r5;
   logic [33:0]      pq, pt;
   logic [24:0]      pc, qc, tc;

   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_src = {valid_ff[NSTG-2:0], in_valid};
   end

   assign in_ready  = en[0];
   assign out_valid = valid_ff[NSTG-1];
   assign out_pixel = pix7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) valid_ff[i] <= valid_src[i];
         end
      end
   end

   // stage 1
   always_comb begin
      q_ext = {3'b0, in_rsp.q_h};
      q_up  = q_ext + {14'b0, in_rsp.rem_nz};
      case (in_rsp.side.region)
         REGION_RED: begin
            h_base = in_rsp.side.neg ? (15'(HUE_FULL) - q_up) : q_ext;
         end
         REGION_GREEN: begin
            h_base = in_rsp.side.neg ? (15'(2 * HUE_SECTOR) - q_up)
                                     : (15'(2 * HUE_SECTOR) + q_ext);
         end
         default: begin
            h_base = in_rsp.side.neg ? (15'(4 * HUE_SECTOR) - q_up)
                                     : (15'(4 * HUE_SECTOR) + q_ext);
         end
      endcase
      hsum1_in = {1'b0, h_base} + {1'b0, hue_offset, 6'b0};
      sp1_in   = {9'b0, in_rsp.q_s} * {17'b0, sat_gain};
   end

   always_ff @(posedge clock) begin
      if (en[0] && valid_src[0]) begin
         hsum1_ff <= hsum1_in;
         sp1_ff   <= sp1_in;
         v1_ff    <= in_rsp.side.value;
      end
   end

   // stage 2: sum stays below three turns
   always_comb begin
      if (hsum1_ff >= 16'(2 * HUE_FULL)) begin
         h2_in = 15'(hsum1_ff - 16'(2 * HUE_FULL));
      end else if (hsum1_ff >= 16'(HUE_FULL)) begin
         h2_in = 15'(hsum1_ff - 16'(HUE_FULL));
      end else begin
         h2_in = hsum1_ff[HUE_W-1:0];
      end
      sat   = sp1_ff[25:8];
      s2_in = (sat > 18'(Q16_ONE)) ? 17'(Q16_ONE) : sat[16:0];
   end

   always_ff @(posedge clock) begin
      if (en[1] && valid_src[1]) begin
         h2_ff <= h2_in;
         s2_ff <= s2_in;
         v2_ff <= v1_ff;
      end
   end

   // stage 3
   always_comb begin
      sec3_in  = '0;
      sec_base = '0;
      for (int k = 1; k < 6; k++) begin
         if (h2_ff >= 15'(k * HUE_SECTOR)) begin
            sec3_in  = 3'(k);
            sec_base = 15'(k * HUE_SECTOR);
         end
      end
      rem3_in = 12'(h2_ff - sec_base);
   end

   always_ff @(posedge clock) begin
      if (en[2] && valid_src[2]) begin
         sec3_ff <= sec3_in;
         rem3_ff <= rem3_in;
         s3_ff   <= s2_ff;
         v3_ff   <= v2_ff;
      end
   end

   // stage 4: rem*256/15 estimate, low by at most one
   always_comb begin
      recip_prod = {16'b0, rem3_ff, 8'b0} * 36'(RECIP_15);
      q4_in      = recip_prod[34:19];
   end

   always_ff @(posedge clock) begin
      if (en[3] && valid_src[3]) begin
         q4_ff   <= q4_in;
         rem4_ff <= rem3_ff;
         sec4_ff <= sec3_ff;
         s4_ff   <= s3_ff;
         v4_ff   <= v3_ff;
      end
   end

   // stage 5
   always_comb begin
      x5    = {rem4_ff, 8'b0};
      q15   = {q4_ff, 4'b0} - {4'b0, q4_ff};
      r5    = x5 - q15;
      f5_in = (r5 >= 20'd15) ? (q4_ff + 16'd1) : q4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4] && valid_src[4]) begin
         f5_ff   <= f5_in;
         sec5_ff <= sec4_ff;
         s5_ff   <= s4_ff;
         v5_ff   <= v4_ff;
      end
   end

   // stage 6
   always_comb begin
      pq     = 34'(s5_ff) * 34'(f5_ff);
      pt     = 34'(s5_ff) * 34'(17'(Q16_ONE) - {1'b0, f5_ff});
      pf6_in = 17'(Q16_ONE) - s5_ff;
      qf6_in = 17'(Q16_ONE) - pq[32:16];
      tf6_in = 17'(Q16_ONE) - pt[32:16];
   end

   always_ff @(posedge clock) begin
      if (en[5] && valid_src[5]) begin
         pf6_ff  <= pf6_in;
         qf6_ff  <= qf6_in;
         tf6_ff  <= tf6_in;
         sec6_ff <= sec5_ff;
         v6_ff   <= v5_ff;
      end
   end

   // stage 7: zero saturation gives unity factors, hence grey
   always_comb begin
      pc = 25'(v6_ff) * 25'(pf6_ff);
      qc = 25'(v6_ff) * 25'(qf6_ff);
      tc = 25'(v6_ff) * 25'(tf6_ff);
      case (sec6_ff)
         3'd0: begin
            pix7_in.red = v6_ff; pix7_in.green = tc[23:16]; pix7_in.blue = pc[23:16];
         end
         3'd1: begin
            pix7_in.red = qc[23:16]; pix7_in.green = v6_ff; pix7_in.blue = pc[23:16];
         end
         3'd2: begin
            pix7_in.red = pc[23:16]; pix7_in.green = v6_ff; pix7_in.blue = tc[23:16];
         end
         3'd3: begin
            pix7_in.red = pc[23:16]; pix7_in.green = qc[23:16]; pix7_in.blue = v6_ff;
         end
         3'd4: begin
            pix7_in.red = tc[23:16]; pix7_in.green = pc[23:16]; pix7_in.blue = v6_ff;
         end
         default: begin
            pix7_in.red = v6_ff; pix7_in.green = pc[23:16]; pix7_in.blue = qc[23:16];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[6] && valid_src[6]) begin
         pix7_ff <= pix7_in;
      end
   end

endmodule
`default_nettype wire
